/* rtl/lce_pkg.sv */
// Package for lru_cache_with_expiry: opcodes, register indexes, state codes.
package lce_pkg;
  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_STORE  = 3'd1,
    OP_REMOVE = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_PURGE  = 3'd4,
    OP_TRIM80 = 3'd5,
    OP_TRIM   = 3'd6,
    OP_NOP    = 3'd7
  } opcode_t;

  localparam logic [1:0] REG_ENABLE  = 2'd0;
  localparam logic [1:0] REG_MAX     = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b00000001,
    ST_SCAN   = 8'b00000010,
    ST_EVICT  = 8'b00000100,
    ST_FIND   = 8'b00001000,
    ST_FREE   = 8'b00010000,
    ST_WRITE  = 8'b00100000,
    ST_CLEAR  = 8'b01000000,
    ST_DONE   = 8'b10000000
  } state_t;
endpackage

/* rtl/lru_cache_with_expiry.sv */
// Top level of the fully associative LRU cache with timeout.
// Slots are scanned one per cycle: lookup/remove and purge take one pass, a store up to
// three (evict pass, key search, free-slot search), and a trim one evict pass per
// evicted entry; clear, NOP and disabled no-ops go straight to the done state.
// One transaction at a time: in_ready is low from acceptance until the result is taken.
// Synchronous active-high reset clears valid bits and counters, sets config registers to defaults and resets control.
module lru_cache_with_expiry import lce_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32,
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           opcode,
  input  logic [KEY_BITS-1:0]  key,
  input  logic [DATA_BITS-1:0] data_in,
  input  logic                 data_valid,
  input  logic [TIME_BITS-1:0] now,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic [DATA_BITS-1:0] data_out,
  output logic [6:0]           entry_count,
  output logic [31:0]          hit_total,
  output logic [31:0]          miss_total,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // slot storage: key/data/stamp in memories, valid bits in flops
  logic [KEY_BITS-1:0]  mem_key   [DEPTH];
  logic [DATA_BITS-1:0] mem_data  [DEPTH];
  logic [TIME_BITS-1:0] mem_stamp [DEPTH];
  logic [DEPTH-1:0]     valid;

  logic                 cache_enable;
  logic [6:0]           max_entries;
  logic [31:0]          timeout_ticks;

  logic [CW-1:0]        occupancy;
  logic [31:0]          hit_counter, miss_counter;

  state_t               state;
  opcode_t              op;
  logic [KEY_BITS-1:0]  r_key;
  logic [DATA_BITS-1:0] r_data;
  logic [TIME_BITS-1:0] r_now;
  logic [CW-1:0]        target;

  // scan pointer; rd_* is registered read data for the slot at rd_idx
  logic [CW-1:0]        idx;
  logic [AW-1:0]        rd_idx;
  logic                 rd_live;
  logic [KEY_BITS-1:0]  rd_key;
  logic [DATA_BITS-1:0] rd_data;
  logic [TIME_BITS-1:0] rd_stamp;

  logic                 found;
  logic [AW-1:0]        found_idx;
  logic [TIME_BITS-1:0] best_age;

  logic                 wr_en;
  logic [AW-1:0]        wr_idx;

  logic [TIME_BITS-1:0] rd_age;
  logic                 expired;
  assign rd_age  = r_now - rd_stamp;
  assign expired = ({{(64-TIME_BITS){1'b0}}, rd_age} > {32'd0, timeout_ticks});

  // APB
  logic wr_cfg;
  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite;
  always_comb begin
    case (paddr[3:2])
      REG_ENABLE:  prdata = {31'd0, cache_enable};
      REG_MAX:     prdata = {25'd0, max_entries};
      REG_TIMEOUT: prdata = timeout_ticks;
      default:     prdata = 32'd0;
    endcase
  end

  assign in_ready = (state == ST_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_idx]   <= r_key;
      mem_data[wr_idx]  <= r_data;
      mem_stamp[wr_idx] <= r_now;
    end
    rd_key   <= mem_key[idx[AW-1:0]];
    rd_data  <= mem_data[idx[AW-1:0]];
    rd_stamp <= mem_stamp[idx[AW-1:0]];
  end

  logic scan_end;
  assign scan_end = (idx == CW'(DEPTH));

  // floor(max_entries*4/5): x/5 == (x*205)>>10 for x below 1024
  logic [16:0] max80_prod;
  logic [8:0]  max80;
  assign max80_prod = {8'd0, max_entries, 2'b00} * 17'd205;
  assign max80      = {2'd0, max80_prod[16:10]};

  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    if (rst) begin
      state         <= ST_IDLE;
      valid         <= '0;
      occupancy     <= '0;
      hit_counter   <= '0;
      miss_counter  <= '0;
      cache_enable  <= 1'b1;
      max_entries   <= (DEPTH < 64) ? 7'(DEPTH) : 7'd64;
      timeout_ticks <= 32'd300;
      out_valid     <= 1'b0;
      rd_live       <= 1'b0;
      idx           <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (wr_cfg) begin
        case (paddr[3:2])
          REG_ENABLE: begin
            cache_enable <= pwdata[0];
            if (!pwdata[0]) begin
              valid <= '0; occupancy <= '0;
              hit_counter <= '0; miss_counter <= '0;
            end
          end
          REG_MAX: begin
            if (pwdata[6:0] == 7'd0) max_entries <= 7'd1;
            else if ({25'd0, pwdata[6:0]} > 32'(DEPTH)) max_entries <= 7'(DEPTH);
            else max_entries <= pwdata[6:0];
          end
          REG_TIMEOUT: timeout_ticks <= (pwdata == 32'd0) ? 32'd1 : pwdata;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            op      <= opcode_t'(opcode);
            r_key   <= key;
            r_data  <= data_in;
            r_now   <= now;
            idx     <= '0;
            rd_live <= 1'b0;
            found   <= 1'b0;
            hit     <= 1'b0;
            data_out <= '0;
            case (opcode_t'(opcode))
              OP_LOOKUP: begin
                if (cache_enable) state <= ST_FIND;
                else begin
                  if (miss_counter != '1) miss_counter <= miss_counter + 32'd1;
                  state <= ST_DONE;
                end
              end
              OP_STORE: begin
                if (!cache_enable || !data_valid) state <= ST_DONE;
                else if ({{(32-CW){1'b0}}, occupancy} >= {25'd0, max_entries})
                  state <= ST_EVICT;
                else state <= ST_FIND;
              end
              OP_REMOVE: state <= ST_FIND;
              OP_CLEAR: begin
                valid <= '0; occupancy <= '0;
                hit_counter <= '0; miss_counter <= '0;
                state <= ST_DONE;
              end
              OP_PURGE: state <= cache_enable ? ST_SCAN : ST_DONE;
              OP_TRIM80: begin
                target <= CW'(max80);
                state  <= cache_enable ? ST_EVICT : ST_DONE;
              end
              OP_TRIM: begin
                target <= CW'(max_entries);
                state  <= cache_enable ? ST_EVICT : ST_DONE;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        // purge: drop each live expired slot
        ST_SCAN: begin
          if (rd_live && expired) begin
            valid[rd_idx] <= 1'b0;
            occupancy <= occupancy - CW'(1);
          end
          rd_live <= !scan_end && valid[idx[AW-1:0]];
          rd_idx  <= idx[AW-1:0];
          if (scan_end) state <= ST_DONE;
          else idx <= idx + CW'(1);
        end
        // one oldest-entry search per pass; trims repeat the pass
        ST_EVICT: begin
          if (rd_live && (!found || rd_age > best_age)) begin
            found <= 1'b1; found_idx <= rd_idx; best_age <= rd_age;
          end
          rd_live <= !scan_end && valid[idx[AW-1:0]];
          rd_idx  <= idx[AW-1:0];
          if (idx == '0 && !rd_live && !found && op != OP_STORE &&
              occupancy <= target) begin
            state <= ST_DONE;
          end else if (scan_end && !rd_live) begin
            if (found) begin
              valid[found_idx] <= 1'b0;
              occupancy <= occupancy - CW'(1);
            end
            found <= 1'b0;
            idx   <= '0;
            if (op == OP_STORE) state <= ST_FIND;
          end else if (!scan_end) idx <= idx + CW'(1);
        end
        // key search
        ST_FIND: begin
          if (rd_live && rd_key == r_key && !found) begin
            found <= 1'b1; found_idx <= rd_idx;
            if (op == OP_LOOKUP) begin
              if (expired) begin
                valid[rd_idx] <= 1'b0;
                occupancy <= occupancy - CW'(1);
                if (miss_counter != '1) miss_counter <= miss_counter + 32'd1;
              end else begin
                hit <= 1'b1; data_out <= rd_data;
                wr_idx <= rd_idx;
                r_data <= rd_data;
                wr_en  <= 1'b1;
                if (hit_counter != '1) hit_counter <= hit_counter + 32'd1;
              end
              state <= ST_DONE;
            end else if (op == OP_REMOVE) begin
              valid[rd_idx] <= 1'b0;
              occupancy <= occupancy - CW'(1);
              state <= ST_DONE;
            end else begin
              wr_idx <= rd_idx;
              state  <= ST_WRITE;
            end
          end else begin
            rd_live <= !scan_end && valid[idx[AW-1:0]];
            rd_idx  <= idx[AW-1:0];
            if (scan_end && !rd_live) begin
              if (op == OP_LOOKUP) begin
                if (miss_counter != '1) miss_counter <= miss_counter + 32'd1;
                state <= ST_DONE;
              end else if (op == OP_STORE) begin
                idx <= '0; state <= ST_FREE;
              end else state <= ST_DONE;
            end else if (!scan_end) idx <= idx + CW'(1);
          end
        end
        // lowest free slot
        ST_FREE: begin
          if (!valid[idx[AW-1:0]]) begin
            wr_idx <= idx[AW-1:0];
            valid[idx[AW-1:0]] <= 1'b1;
            occupancy <= occupancy + CW'(1);
            state <= ST_WRITE;
          end else if (idx == CW'(DEPTH - 1)) state <= ST_DONE;
          else idx <= idx + CW'(1);
        end
        ST_WRITE: begin
          wr_en <= 1'b1;
          state <= ST_DONE;
        end
        ST_CLEAR: state <= ST_DONE;
        ST_DONE: begin
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign entry_count = 7'(occupancy);
  assign hit_total   = hit_counter;
  assign miss_total  = miss_counter;
endmodule

/* rtl/lce_checker.sv */
// Port-level checker for lru_cache_with_expiry, with its bind.
module lce_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [31:0] data_out,
  input logic [6:0]  entry_count
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accepted while busy");
  a_out_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_out))
    else $error("result dropped");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> data_out == 32'd0) else $error("miss with data");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= 7'd64) else $error("count overflow");
endmodule

bind lru_cache_with_expiry lce_checker u_lce_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .hit(hit),
  .data_out(data_out), .entry_count(entry_count)
);
